@@ hw/rtl/dlr_pkg.sv @@
// Shared types and constants of the DDA line rasteriser.
package dlr_pkg;

  localparam int unsigned COORD_W     = 5;
  localparam int unsigned COLOUR_W    = 8;
  localparam int unsigned FRAME_W_DEF = 32;
  localparam int unsigned FRAME_H_DEF = 32;
  localparam int unsigned DIV_STEPS   = COORD_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [COLOUR_W-1:0] FULL_ON = 8'hFF;
  localparam logic [COLOUR_W-1:0] ALL_OFF = 8'h00;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [COLOUR_W-1:0] colour_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_t;

  typedef struct packed {
    coord_t  pixel_x;
    coord_t  pixel_y;
    colour_t red;
    colour_t green;
    colour_t blue;
    logic    last_pixel;
  } pixel_t;

  typedef struct packed {
    coord_t quot;
    coord_t rem;
  } div_res_t;

endpackage

@@ hw/rtl/dda_line_rasterizer.sv @@
// DDA line rasteriser: turns a line segment into an ordered stream of pixel writes.
//
// Command channel: line_i is taken at a rising edge with start_i high and busy_o low.
// Result channel: each pixel write sits on pixel_o for one cycle with pixel_valid_o
// high and is transferred at the edge that ends that cycle; the receiver cannot stall.
// Order per line: white line pixels, a red pixel at the start point, then a green
// pixel at the end point with last_pixel set. Pixels with x >= WIDTH or y >= HEIGHT
// are dropped, the red and green ones included.
// Sequencing: a vertical line (equal x) needs no division and goes straight to its
// pixels. Any other line first runs the 5-step restoring divider for floor(dy / dx);
// then every line steps one pixel per cycle through a single add and compare on the
// remainder. Results are registered behind the sequencer, so the last write appears
// in the first cycle in which busy_o is low again.
// At most 33 writes per line, one per cycle; one line at a time.
// Reset clears the sequencer and the result strobe; a line in flight is abandoned.
module dda_line_rasterizer
  import dlr_pkg::*;
#(
  parameter int unsigned WIDTH  = FRAME_W_DEF,
  parameter int unsigned HEIGHT = FRAME_H_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  line_t  line_i,
  output logic   busy_o,
  output logic   pixel_valid_o,
  output pixel_t pixel_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_LINE  = 5'b00100,
    ST_RED   = 5'b01000,
    ST_GREEN = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  line_t    line_q, line_d;
  coord_t   x_q, x_d;
  coord_t   y_q, y_d;
  coord_t   dx_q, dx_d;
  coord_t   r_q, r_d;
  coord_t   rd_q, rd_d;
  coord_t   qd_q, qd_d;
  coord_t   cnt_q, cnt_d;
  logic     xinc_q, xinc_d;
  logic     neg_q, neg_d;
  logic     valid_q, valid_d;
  pixel_t   pix_q, pix_d;

  logic     accept;
  logic     vert;
  logic     right;
  coord_t   xl, yl, xr, yr;
  coord_t   ylo, vlen;
  coord_t   dx_in, absdy_in;
  logic     neg_in;
  logic     div_done;
  div_res_t div_res;
  logic [COORD_W:0] sum;
  logic     carry;
  logic     emit;
  pixel_t   cand;
  logic     in_frame;

  assign accept = start_i && (state_q == ST_IDLE);
  assign vert   = line_i.start_x == line_i.end_x;
  assign right  = line_i.end_x > line_i.start_x;
  assign xl     = right ? line_i.start_x : line_i.end_x;
  assign yl     = right ? line_i.start_y : line_i.end_y;
  assign xr     = right ? line_i.end_x : line_i.start_x;
  assign yr     = right ? line_i.end_y : line_i.start_y;
  assign dx_in  = xr - xl;
  assign neg_in = yr < yl;
  assign absdy_in = neg_in ? (yl - yr) : (yr - yl);
  assign ylo  = (line_i.start_y < line_i.end_y) ? line_i.start_y : line_i.end_y;
  assign vlen = (line_i.start_y < line_i.end_y) ? (line_i.end_y - line_i.start_y)
                                                : (line_i.start_y - line_i.end_y);

  dlr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && !vert),
    .dividend_i (absdy_in),
    .divisor_i  (dx_in),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  assign sum   = {1'b0, r_q} + {1'b0, rd_q};
  assign carry = sum >= {1'b0, dx_q};

  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    x_d     = x_q;
    y_d     = y_q;
    dx_d    = dx_q;
    r_d     = r_q;
    rd_d    = rd_q;
    qd_d    = qd_q;
    cnt_d   = cnt_q;
    xinc_d  = xinc_q;
    neg_d   = neg_q;
    emit    = 1'b0;
    cand    = '{pixel_x: x_q, pixel_y: y_q, red: FULL_ON, green: FULL_ON,
                blue: FULL_ON, last_pixel: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          line_d = line_i;
          r_d    = '0;
          if (vert) begin
            x_d    = line_i.start_x;
            y_d    = ylo;
            dx_d   = COORD_W'(1);
            rd_d   = '0;
            qd_d   = COORD_W'(1);
            cnt_d  = vlen;
            xinc_d = 1'b0;
            state_d = (vlen == '0) ? ST_RED : ST_LINE;
          end else begin
            x_d    = xl;
            y_d    = yl;
            dx_d   = dx_in;
            cnt_d  = dx_in;
            neg_d  = neg_in;
            xinc_d = 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (!neg_q) begin
            qd_d = div_res.quot;
            rd_d = div_res.rem;
          end else if (div_res.rem == '0) begin
            qd_d = COORD_W'(0) - div_res.quot;
            rd_d = '0;
          end else begin
            qd_d = ~div_res.quot;
            rd_d = dx_q - div_res.rem;
          end
          state_d = ST_LINE;
        end
      end
      ST_LINE: begin
        emit  = 1'b1;
        x_d   = x_q + COORD_W'(xinc_q);
        y_d   = y_q + qd_q + COORD_W'(carry);
        r_d   = carry ? COORD_W'(sum - {1'b0, dx_q}) : sum[COORD_W-1:0];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == COORD_W'(1)) begin
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        emit = 1'b1;
        cand = '{pixel_x: line_q.start_x, pixel_y: line_q.start_y, red: FULL_ON,
                 green: ALL_OFF, blue: ALL_OFF, last_pixel: 1'b0};
        state_d = ST_GREEN;
      end
      ST_GREEN: begin
        emit = 1'b1;
        cand = '{pixel_x: line_q.end_x, pixel_y: line_q.end_y, red: ALL_OFF,
                 green: FULL_ON, blue: ALL_OFF, last_pixel: 1'b1};
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_frame = ({2'b00, cand.pixel_x} < (COORD_W + 2)'(WIDTH)) &&
                    ({2'b00, cand.pixel_y} < (COORD_W + 2)'(HEIGHT));
  assign valid_d  = emit && in_frame;
  assign pix_d    = cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    x_q    <= x_d;
    y_q    <= y_d;
    dx_q   <= dx_d;
    r_q    <= r_d;
    rd_q   <= rd_d;
    qd_q   <= qd_d;
    cnt_q  <= cnt_d;
    xinc_q <= xinc_d;
    neg_q  <= neg_d;
    pix_q  <= pix_d;
  end

  assign busy_o        = state_q != ST_IDLE;
  assign pixel_valid_o = valid_q;
  assign pixel_o       = pix_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted line did not raise busy");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && pixel_o.last_pixel) |-> !busy_o)
    else $error("last pixel transferred while still busy");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINE) |-> ((r_q < dx_q) && (rd_q < dx_q)))
    else $error("step remainder out of range");

endmodule

@@ hw/rtl/dlr_div.sv @@
// Restoring divider of two coordinates, one quotient bit per cycle.
module dlr_div
  import dlr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  coord_t   dividend_i,
  input  coord_t   divisor_i,
  output logic     done_o,
  output div_res_t res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  coord_t               dvd_q, dvd_d;
  coord_t               rem_q, rem_d;
  coord_t               dsr_q, dsr_d;
  logic [COORD_W:0]     trial;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, dvd_q[COORD_W-1]};
    ge     = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? COORD_W'(trial - {1'b0, dsr_q}) : trial[COORD_W-1:0];
      dvd_d = {dvd_q[COORD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o   = done_q;
  assign res_o.quot = dvd_q;
  assign res_o.rem  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dsr_q))
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while running");

endmodule

@@ tb/sv/dda_line_rasterizer_test.sv @@
// Self-checking testbench of the DDA line rasteriser: directed table, then random lines.
module dda_line_rasterizer_test
  import dlr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W = FRAME_W_DEF;
  localparam int FRAME_H = FRAME_H_DEF;
  localparam int MAX_PIXELS = 33;
  localparam int RAND_LINES = 450;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    line_t  seg;
    bit     typed;
    pixel_t red_px;
    pixel_t green_px;
  } line_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  line_t  line_i = '0;
  logic   busy_o;
  logic   pixel_valid_o;
  pixel_t pixel_o;

  pixel_t pending_pixels[$];
  int     err_cnt = 0;
  bit     idle_en = 1'b1;

  dda_line_rasterizer #(
    .WIDTH  (FRAME_W),
    .HEIGHT (FRAME_H)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .line_i        (line_i),
    .busy_o        (busy_o),
    .pixel_valid_o (pixel_valid_o),
    .pixel_o       (pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int floor_quot(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic void push_pixel(inout int n, input int x, input int y,
                                     input colour_t r, input colour_t g, input colour_t b,
                                     input logic last);
    pixel_t px;
    if (x < 0 || y < 0 || x >= FRAME_W || y >= FRAME_H || n >= MAX_PIXELS) return;
    px.pixel_x    = coord_t'(x);
    px.pixel_y    = coord_t'(y);
    px.red        = r;
    px.green      = g;
    px.blue       = b;
    px.last_pixel = last;
    pending_pixels.push_back(px);
    n++;
  endfunction

  function automatic void predict_line(line_t seg);
    int x1, y1, x2, y2, xl, yl, dx, dy, n;
    x1 = int'(seg.start_x);
    y1 = int'(seg.start_y);
    x2 = int'(seg.end_x);
    y2 = int'(seg.end_y);
    n  = 0;
    if (x1 == x2) begin
      yl = (y1 < y2) ? y1 : y2;
      dy = (y1 < y2) ? (y2 - y1) : (y1 - y2);
      for (int k = 0; k < dy; k++)
        push_pixel(n, x1, yl + k, FULL_ON, FULL_ON, FULL_ON, 1'b0);
    end else begin
      if (x2 > x1) begin
        xl = x1; yl = y1; dx = x2 - x1; dy = y2 - y1;
      end else begin
        xl = x2; yl = y2; dx = x1 - x2; dy = y1 - y2;
      end
      for (int k = 0; k < dx; k++)
        push_pixel(n, xl + k, yl + floor_quot(dy * k, dx), FULL_ON, FULL_ON, FULL_ON, 1'b0);
    end
    push_pixel(n, x1, y1, FULL_ON, ALL_OFF, ALL_OFF, 1'b0);
    push_pixel(n, x2, y2, ALL_OFF, FULL_ON, ALL_OFF, 1'b1);
  endfunction

  task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && pixel_valid_o) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel: unexpected transfer x=%0d y=%0d", pixel_o.pixel_x, pixel_o.pixel_y);
        err_cnt++;
      end else begin
        exp_px = pending_pixels.pop_front();
        report_field("pixel_x", exp_px.pixel_x, pixel_o.pixel_x);
        report_field("pixel_y", exp_px.pixel_y, pixel_o.pixel_y);
        report_field("red", exp_px.red, pixel_o.red);
        report_field("green", exp_px.green, pixel_o.green);
        report_field("blue", exp_px.blue, pixel_o.blue);
        report_field("last_pixel", exp_px.last_pixel, pixel_o.last_pixel);
      end
    end
  end

  // Hold start until the line is taken; idle cycles go in front of it.
  task automatic send_line(line_t seg);
    while (idle_en && $urandom_range(0, 99) < 21) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    line_i  <= seg;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 31) return coord_t'(31);
    return coord_t'(v);
  endfunction

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    line_row_t dir_rows [16];
    line_t     seg;
    int        pick;

    dir_rows = '{
      '{'{5'd0, 5'd0, 5'd0, 5'd0}, 1'b1,
        '{5'd0, 5'd0, FULL_ON, ALL_OFF, ALL_OFF, 1'b0},
        '{5'd0, 5'd0, ALL_OFF, FULL_ON, ALL_OFF, 1'b1}},
      '{'{5'd31, 5'd31, 5'd31, 5'd31}, 1'b1,
        '{5'd31, 5'd31, FULL_ON, ALL_OFF, ALL_OFF, 1'b0},
        '{5'd31, 5'd31, ALL_OFF, FULL_ON, ALL_OFF, 1'b1}},
      '{'{5'd0, 5'd0, 5'd31, 5'd31}, 1'b0, '0, '0},
      '{'{5'd31, 5'd31, 5'd0, 5'd0}, 1'b0, '0, '0},
      '{'{5'd0, 5'd31, 5'd31, 5'd0}, 1'b0, '0, '0},
      '{'{5'd31, 5'd0, 5'd0, 5'd31}, 1'b0, '0, '0},
      '{'{5'd0, 5'd0, 5'd31, 5'd0}, 1'b0, '0, '0},
      '{'{5'd31, 5'd5, 5'd0, 5'd5}, 1'b0, '0, '0},
      '{'{5'd7, 5'd0, 5'd7, 5'd31}, 1'b0, '0, '0},
      '{'{5'd7, 5'd31, 5'd7, 5'd0}, 1'b0, '0, '0},
      '{'{5'd3, 5'd4, 5'd3, 5'd5}, 1'b0, '0, '0},
      '{'{5'd0, 5'd0, 5'd1, 5'd31}, 1'b0, '0, '0},
      '{'{5'd1, 5'd31, 5'd0, 5'd0}, 1'b0, '0, '0},
      '{'{5'd10, 5'd10, 5'd11, 5'd10}, 1'b0, '0, '0},
      '{'{5'd0, 5'd10, 5'd3, 5'd8}, 1'b0, '0, '0},
      '{'{5'd5, 5'd20, 5'd25, 5'd3}, 1'b0, '0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_line(dir_rows[i].seg);
      if (dir_rows[i].typed) begin
        pending_pixels.push_back(dir_rows[i].red_px);
        pending_pixels.push_back(dir_rows[i].green_px);
      end else begin
        predict_line(dir_rows[i].seg);
      end
    end

    start_i <= 1'b0;
    wait_drained();

    for (int i = 0; i < RAND_LINES; i++) begin
      idle_en = !(i >= 150 && i < 250);
      if (i == 320) begin
        start_i <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      seg  = line_t'($urandom);
      if (pick >= 60 && pick < 75) begin
        seg.end_x = clamp_coord(int'(seg.start_x) + $urandom_range(0, 6) - 3);
        seg.end_y = clamp_coord(int'(seg.start_y) + $urandom_range(0, 6) - 3);
      end else if (pick >= 75 && pick < 85) begin
        seg.end_x = seg.start_x;
      end else if (pick >= 85 && pick < 92) begin
        seg.end_y = seg.start_y;
      end else if (pick >= 92) begin
        seg.end_x = seg.start_x;
        seg.end_y = seg.start_y;
      end
      send_line(seg);
      predict_line(seg);
    end

    start_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dlr_pkg.sv
hw/rtl/dlr_div.sv
hw/rtl/dda_line_rasterizer.sv
tb/sv/dda_line_rasterizer_test.sv
